/* rtl/assert_macros.svh */
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// consequent must hold in the cycle the antecedent holds
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/vsfam_pkg.sv */
// types, constants and helper functions of the vital sign frame alarm monitor
`timescale 1ns / 1ps

package vsfam_pkg;

   // link protocol bytes
   localparam logic [7:0] KEY_BYTE      = 8'h37;
   localparam logic [7:0] PREAMBLE_BYTE = 8'h40;
   localparam logic [7:0] ALARM_MARK    = 8'h21;
   localparam logic [7:0] ADDR_HEART    = 8'h31;
   localparam logic [7:0] ADDR_TEMP     = 8'h54;
   localparam logic [7:0] ADDR_RIGHT    = 8'h42;
   localparam logic [7:0] ADDR_LEFT     = 8'h62;
   localparam logic [7:0] ADDR_TEST     = 8'h30;
   localparam logic [7:0] TEST_DATA     = 8'h00;

   localparam logic [5:0] ASCII_ZERO        = 6'd48;
   localparam logic [5:0] MAX_HUNDREDS_CHAR = 6'd50;

   // result kinds
   localparam logic KIND_DISPLAY = 1'b0;
   localparam logic KIND_ALARM   = 1'b1;

   // display lines
   localparam logic [1:0] LINE_HEART = 2'd0;
   localparam logic [1:0] LINE_TEMP  = 2'd1;
   localparam logic [1:0] LINE_RIGHT = 2'd2;
   localparam logic [1:0] LINE_LEFT  = 2'd3;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEART_LOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEART_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_GAP = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEST_PERIOD  = 3'd5;

   // positions inside a 7-byte alarm frame
   localparam int BYTE_IDX_W = 3;
   localparam logic [BYTE_IDX_W-1:0] IDX_FIRST = 3'd0;
   localparam logic [BYTE_IDX_W-1:0] IDX_MARK  = 3'd3;
   localparam logic [BYTE_IDX_W-1:0] IDX_ADDR  = 3'd4;
   localparam logic [BYTE_IDX_W-1:0] IDX_DATA  = 3'd5;
   localparam logic [BYTE_IDX_W-1:0] IDX_SUM   = 3'd6;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_ADDR,
      PH_DATA,
      PH_SUM
   } phase_type;

   typedef enum logic [1:0] {
      SEG_IDLE,
      SEG_DISPLAY,
      SEG_VALUE,
      SEG_TEST
   } seg_type;

   typedef struct packed {
      logic [7:0] heart_low;
      logic [7:0] heart_high;
      logic [7:0] temp_low;
      logic [7:0] temp_high;
      logic [7:0] pressure_gap;
      logic [7:0] test_period;
   } cfg_type;

   typedef struct packed {
      logic [1:0] hundreds;
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   // everything one received byte asks the back to send
   typedef struct packed {
      logic       has_display;
      logic [1:0] line;
      digits_type digits;
      logic       has_value;
      logic [7:0] value_addr;
      logic [7:0] value_data;
      logic       has_test;
   } job_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   // decimal split of an 8-bit value, tens by reciprocal multiply
   function automatic digits_type to_digits(input logic [7:0] value);
      logic [1:0]  h;
      logic [6:0]  rem;
      logic [15:0] prod;
      logic [3:0]  t;
      logic [6:0]  tens_x10;
      digits_type  d;
      if (value >= 8'd200) begin
         h   = 2'd2;
         rem = 7'(value - 8'd200);
      end else if (value >= 8'd100) begin
         h   = 2'd1;
         rem = 7'(value - 8'd100);
      end else begin
         h   = 2'd0;
         rem = value[6:0];
      end
      prod       = {9'd0, rem} * 16'd205;
      t          = prod[14:11];
      tens_x10   = 7'({3'd0, t} * 7'd10);
      d.hundreds = h;
      d.tens     = t;
      d.ones     = 4'(rem - tens_x10);
      return d;
   endfunction

   function automatic logic [7:0] alarm_byte(input logic [BYTE_IDX_W-1:0] idx,
                                             input logic [7:0] addr,
                                             input logic [7:0] data);
      logic [7:0] b;
      case (idx)
         IDX_MARK: b = ALARM_MARK;
         IDX_ADDR: b = addr;
         IDX_DATA: b = data;
         IDX_SUM:  b = 8'(addr + data);
         default:  b = PREAMBLE_BYTE;
      endcase
      return b;
   endfunction

endpackage

/* rtl/vital_sign_frame_alarm_monitor_core.sv */
// top level of the vital sign frame alarm monitor: limit registers and block wiring
`timescale 1ns / 1ps

// The monitor parses sensor link bytes (keyword 0x37, address, data, checksum) and for every
// byte returns its results in order: a display record with three ASCII digits for a good
// frame, a 7-byte alarm frame when heart or temperature leaves its limits or the two arm
// pressures differ by the gap or more, and the periodic test alarm frame. The last result of
// a byte carries rsp_last; a byte that causes nothing gives no transaction at all. The parser
// takes one byte per cycle as long as the two-entry job queue has room. The result sequencer
// loads a job while idle, then plays out its results, at most a display record plus two
// alarm frames, and holds while rsp_stall is set; it takes a new job only after the last
// result of the one before. Bytes without results never reach it. Limit registers are
// written through the csr_ port, which is always ready, and take effect on the next byte.

`include "assert_macros.svh"

module vital_sign_frame_alarm_monitor_core (
   input  logic                              clock,
   input  logic                              reset,
   // received byte transactions
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   // result transactions
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [1:0]                        rsp_line,
   output logic [5:0]                        rsp_hundreds_char,
   output logic [5:0]                        rsp_tens_char,
   output logic [5:0]                        rsp_ones_char,
   output logic [7:0]                        rsp_tx_byte,
   output logic                              rsp_last,
   // limit register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vsfam_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_wdata
);
   import vsfam_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            q_push;
   job_type         q_push_job;
   logic            q_full;
   logic            q_pop;
   job_type         q_pop_job;
   logic            q_empty;
   back_status_type back_status;
   logic            rsp_is_display;
   logic            display_fields_ok;

   // register file, writes never stall
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEART_LOW:    cfg_in.heart_low    = csr_wdata;
            CSR_HEART_HIGH:   cfg_in.heart_high   = csr_wdata;
            CSR_TEMP_LOW:     cfg_in.temp_low     = csr_wdata;
            CSR_TEMP_HIGH:    cfg_in.temp_high    = csr_wdata;
            CSR_PRESSURE_GAP: cfg_in.pressure_gap = csr_wdata;
            CSR_TEST_PERIOD:  cfg_in.test_period  = csr_wdata;
            default: ;  // writes past the list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heart_low    <= 8'd60;
         cfg_ff.heart_high   <= 8'd110;
         cfg_ff.temp_low     <= 8'd36;
         cfg_ff.temp_high    <= 8'd38;
         cfg_ff.pressure_gap <= 8'd10;
         cfg_ff.test_period  <= 8'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // parser: keeps frame phase, stored pressures and attempt count
   vsfam_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .push        (q_push),
      .push_job    (q_push_job),
      .q_full      (q_full)
   );

   // jobs waiting for the sequencer
   vsfam_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (q_pop_job),
      .empty    (q_empty)
   );

   // sequencer with output register
   vsfam_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_job             (q_pop_job),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_line          (rsp_line),
      .rsp_hundreds_char (rsp_hundreds_char),
      .rsp_tens_char     (rsp_tens_char),
      .rsp_ones_char     (rsp_ones_char),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last          (rsp_last),
      .status            (back_status)
   );

   assign rsp_is_display    = rsp_valid && (rsp_kind == KIND_DISPLAY);
   assign display_fields_ok = (rsp_tx_byte == 8'd0) && (rsp_hundreds_char <= MAX_HUNDREDS_CHAR);

   // a job is never pushed into a full queue
   `ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(q_push && q_full))
   // a result that is not the last one leaves the sequencer busy with the rest
   `ASSERT_IMPLY(a_more_pending, clock, reset, rsp_valid && !rsp_last, back_status.busy)
   // display records carry no tx byte and a hundreds digit of two at most
   `ASSERT_IMPLY(a_display_fields, clock, reset, rsp_is_display, display_fields_ok)

endmodule

/* rtl/vsfam_front.sv */
// frame parser: accepts received bytes and turns those with results into result jobs
`timescale 1ns / 1ps

module vsfam_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  vsfam_pkg::cfg_type cfg,
   output logic              push,
   output vsfam_pkg::job_type push_job,
   input  logic              q_full
);
   import vsfam_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] right_ff, right_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] count_ff, count_in;

   logic       accept;
   logic       known;
   logic       attempt;
   logic       sum_ok;
   logic [7:0] count_inc;
   logic       test_due;
   logic [7:0] diff_rl;
   logic [7:0] diff_lr;
   logic       value_alarm;
   logic [7:0] alarm_addr;
   logic [7:0] alarm_data;
   logic [1:0] line;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign known = (req_rx_byte == ADDR_HEART) || (req_rx_byte == ADDR_TEMP) ||
                  (req_rx_byte == ADDR_RIGHT) || (req_rx_byte == ADDR_LEFT);

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == KEY_BYTE) phase_in = PH_ADDR;
            end
            PH_ADDR: begin
               phase_in = known ? PH_DATA : PH_HUNT;
            end
            PH_DATA: phase_in = PH_SUM;
            PH_SUM:  phase_in = PH_HUNT;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   assign sum_ok    = (8'(addr_ff + data_ff) == req_rx_byte);
   assign count_inc = 8'(count_ff + 8'd1);
   assign test_due  = (count_inc >= cfg.test_period);
   assign diff_rl   = 8'(right_ff - data_ff);
   assign diff_lr   = 8'(data_ff - right_ff);

   // classification and job contents
   always_comb begin
      attempt     = 1'b0;
      value_alarm = 1'b0;
      alarm_addr  = addr_ff;
      alarm_data  = data_ff;
      line        = LINE_LEFT;
      addr_in     = addr_ff;
      data_in     = data_ff;
      right_in    = right_ff;
      left_in     = left_ff;

      unique case (addr_ff)
         ADDR_HEART: begin
            line        = LINE_HEART;
            value_alarm = (data_ff > cfg.heart_high) || (data_ff < cfg.heart_low);
         end
         ADDR_TEMP: begin
            line        = LINE_TEMP;
            value_alarm = (data_ff > cfg.temp_high) || (data_ff < cfg.temp_low);
         end
         ADDR_RIGHT: line = LINE_RIGHT;
         default: begin
            // left pressure compares against the stored right pressure
            line = LINE_LEFT;
            if (right_ff >= data_ff) begin
               value_alarm = (diff_rl >= cfg.pressure_gap);
               alarm_addr  = ADDR_RIGHT;
               alarm_data  = diff_rl;
            end else begin
               value_alarm = (diff_lr >= cfg.pressure_gap);
               alarm_addr  = ADDR_LEFT;
               alarm_data  = diff_lr;
            end
         end
      endcase

      push_job.has_display = 1'b0;
      push_job.line        = line;
      push_job.digits      = to_digits(data_ff);
      push_job.has_value   = 1'b0;
      push_job.value_addr  = alarm_addr;
      push_job.value_data  = alarm_data;

      if (accept) begin
         unique case (phase_ff)
            PH_ADDR: begin
               addr_in = req_rx_byte;
               attempt = !known;
            end
            PH_DATA: data_in = req_rx_byte;
            PH_SUM: begin
               attempt = 1'b1;
               if (sum_ok) begin
                  push_job.has_display = 1'b1;
                  push_job.has_value   = value_alarm;
                  if (addr_ff == ADDR_RIGHT) right_in = data_ff;
                  if (addr_ff == ADDR_LEFT)  left_in  = data_ff;
               end
            end
            default: ;
         endcase
      end

      push_job.has_test = attempt && test_due;
      count_in = attempt ? (test_due ? 8'd0 : count_inc) : count_ff;
      push     = push_job.has_display || push_job.has_test;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         addr_ff  <= 8'd0;
         data_ff  <= 8'd0;
         right_ff <= 8'd0;
         left_ff  <= 8'd0;
         count_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         right_ff <= right_in;
         left_ff  <= left_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/vsfam_queue.sv */
// short job queue between the parser and the result sequencer
`timescale 1ns / 1ps

module vsfam_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vsfam_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output vsfam_pkg::job_type pop_job,
   output logic               empty
);
   import vsfam_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : QUEUE_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : QUEUE_PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop)      count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      else if (do_pop && !do_push) count_in = QUEUE_CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

/* rtl/vsfam_back.sv */
// result sequencer: plays each job out as display records and alarm bytes
`timescale 1ns / 1ps

module vsfam_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  vsfam_pkg::job_type         q_job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kind,
   output logic [1:0]                 rsp_line,
   output logic [5:0]                 rsp_hundreds_char,
   output logic [5:0]                 rsp_tens_char,
   output logic [5:0]                 rsp_ones_char,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_last,
   output vsfam_pkg::back_status_type status
);
   import vsfam_pkg::*;

   seg_type               seg_ff, seg_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   job_type               job_ff, job_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       kind_ff, kind_in;
   logic [1:0] line_ff, line_in;
   logic [5:0] hund_ff, hund_in;
   logic [5:0] tens_ff, tens_in;
   logic [5:0] ones_ff, ones_in;
   logic [7:0] tx_ff, tx_in;
   logic       last_ff, last_in;

   logic advance;
   logic emit;

   // output register free or being taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = (seg_ff == SEG_IDLE) && !q_empty;
   assign job_in  = pop ? q_job : job_ff;

   // next segment and byte position
   always_comb begin
      seg_in = seg_ff;
      idx_in = idx_ff;
      unique case (seg_ff)
         SEG_IDLE: begin
            if (!q_empty) begin
               if (q_job.has_display)    seg_in = SEG_DISPLAY;
               else if (q_job.has_value) seg_in = SEG_VALUE;
               else                      seg_in = SEG_TEST;
            end
         end
         SEG_DISPLAY: begin
            if (advance) begin
               if (job_ff.has_value)     seg_in = SEG_VALUE;
               else if (job_ff.has_test) seg_in = SEG_TEST;
               else                      seg_in = SEG_IDLE;
            end
         end
         SEG_VALUE: begin
            if (advance) begin
               if (idx_ff == IDX_SUM) begin
                  idx_in = IDX_FIRST;
                  seg_in = job_ff.has_test ? SEG_TEST : SEG_IDLE;
               end else begin
                  idx_in = BYTE_IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         SEG_TEST: begin
            if (advance) begin
               if (idx_ff == IDX_SUM) begin
                  idx_in = IDX_FIRST;
                  seg_in = SEG_IDLE;
               end else begin
                  idx_in = BYTE_IDX_W'(idx_ff + 1'b1);
               end
            end
         end
         default: seg_in = SEG_IDLE;
      endcase
   end

   // result fields for the current position
   always_comb begin
      emit    = advance && (seg_ff != SEG_IDLE);
      kind_in = KIND_ALARM;
      line_in = LINE_HEART;
      hund_in = ASCII_ZERO;
      tens_in = ASCII_ZERO;
      ones_in = ASCII_ZERO;
      tx_in   = 8'd0;
      last_in = (seg_in == SEG_IDLE);
      unique case (seg_ff)
         SEG_DISPLAY: begin
            kind_in = KIND_DISPLAY;
            line_in = job_ff.line;
            hund_in = 6'(ASCII_ZERO + {4'd0, job_ff.digits.hundreds});
            tens_in = 6'(ASCII_ZERO + {2'd0, job_ff.digits.tens});
            ones_in = 6'(ASCII_ZERO + {2'd0, job_ff.digits.ones});
         end
         SEG_VALUE: tx_in = alarm_byte(idx_ff, job_ff.value_addr, job_ff.value_data);
         SEG_TEST:  tx_in = alarm_byte(idx_ff, ADDR_TEST, TEST_DATA);
         default: ;
      endcase
      rsp_valid_in = advance ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_IDLE;
         idx_ff       <= IDX_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         kind_ff <= kind_in;
         line_ff <= line_in;
         hund_ff <= hund_in;
         tens_ff <= tens_in;
         ones_ff <= ones_in;
         tx_ff   <= tx_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_line          = line_ff;
   assign rsp_hundreds_char = hund_ff;
   assign rsp_tens_char     = tens_ff;
   assign rsp_ones_char     = ones_ff;
   assign rsp_tx_byte       = tx_ff;
   assign rsp_last          = last_ff;
   assign status.busy       = (seg_ff != SEG_IDLE);

endmodule
